// ===== sv/gdad_pkg.sv =====
// Package for the Gregorian date adder: transaction types, status codes,
// controller/datapath command and status types and calendar lookup functions.
// No dependencies.
package gdad_pkg;

    // Largest year that the calendar covers.
    localparam logic [13:0] YEAR_MAX = 14'd9999;

    // Reciprocal of 100 for the start year: q = (y * RECIP_100) >> RECIP_SHIFT.
    localparam logic [12:0] RECIP_100   = 13'd5243;
    localparam int          RECIP_SHIFT = 19;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_INVALID  = 2'd2;

    // Input transaction.
    typedef struct packed {
        logic [13:0] start_year;
        logic [3:0]  start_month;
        logic [4:0]  start_day;
        logic [15:0] days_to_add;
    } in_t;

    // Result transaction.
    typedef struct packed {
        logic [13:0] new_year;
        logic [3:0]  new_month;
        logic [4:0]  new_day;
        logic [1:0]  status;
    } out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;    // capture a new transaction
        logic quot;    // register year / 100
        logic rem;     // register year % 100 and the century bits
        logic check;   // validate and form the day count
        logic step;    // one month of the walk
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic invalid;  // start date is not a real date
        logic fits;     // remaining days fall in the current month
        logic overflow; // the walk would pass December of the last year
    } dp_stat_t;

    // Leap rule from incrementally kept residues: the low two year bits,
    // the year modulo 100 and the low two bits of the century number.
    function automatic logic is_leap(logic [1:0] year_lo, logic [6:0] rem100,
                                     logic [1:0] cent_lo);
        logic by4;
        logic cent;
        by4  = (year_lo == 2'd0);
        cent = (rem100 == 7'd0);
        return (by4 && !cent) || (cent && (cent_lo == 2'd0));
    endfunction

    // Length of a month; zero for a code that is not a month.
    function automatic logic [4:0] month_len(logic [3:0] m, logic leap);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days in the months before month m of a common year.
    function automatic logic [8:0] days_before(logic [3:0] m);
        logic [8:0] d;
        unique case (m)
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// ===== sv/gregorian_date_add_days.sv =====
// Top level of the Gregorian date adder: controller plus datapath.
// Depends on gdad_pkg, gdad_ctrl and gdad_dp.
//
//  Channel   Handshake             Payload            Direction
//  -------   -------------------   ----------------   ---------
//  request   start, busy           item   (in_t)      in
//  result    done (one cycle)      result (out_t)     out
//
// A transaction is taken when start is high and busy is low.
// An accepted transaction passes the quotient, remainder and check states, then the
// walk loop, which steps one month per cycle, and ends in the finish state.
// An invalid start date skips the walk and goes from check straight to finish.
// Reset returns the controller to idle; no result is pending after reset.
// The result is shown on done for exactly one cycle; the receiver cannot stall.
module gregorian_date_add_days (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  gdad_pkg::in_t   item,
    output logic            busy,
    output logic            done,
    output gdad_pkg::out_t  result
);
    import gdad_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // Sequencer.
    gdad_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .cmd   (cmd),
        .busy  (busy),
        .done  (done)
    );

    // Arithmetic and result register.
    gdad_dp u_dp (
        .clk    (clk),
        .item   (item),
        .cmd    (cmd),
        .stat   (stat),
        .result (result)
    );

`ifndef SYNTH
    // An accepted transaction makes the block busy in the next cycle.
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("block not busy after accepting a transaction");

    // A result strobe lasts exactly one cycle.
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done held longer than one cycle");

    // The result is strobed only while the block still holds the transaction.
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done without a transaction in flight");

    // A good result carries a real month and day.
    a_ok_date: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (result.status == ST_OK)) |->
            (result.new_month >= 4'd1) && (result.new_month <= 4'd12) &&
            (result.new_day != 5'd0) && (result.new_year != 14'd0))
        else $error("ok result with an impossible date");
`endif

endmodule

// ===== sv/gdad_ctrl.sv =====
// Controller state machine of the Gregorian date adder.
// Sequences load, residue setup, validation and the month walk.
// Depends on gdad_pkg.
module gdad_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  gdad_pkg::dp_stat_t  stat,
    output gdad_pkg::dp_cmd_t   cmd,
    output logic                busy,
    output logic                done
);
    import gdad_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_QUOT  = 6'b000010,
        S_REM   = 6'b000100,
        S_CHECK = 6'b001000,
        S_WALK  = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_QUOT;
                end
            end
            S_QUOT:
            begin
                cmd.quot   = 1'b1;
                state_next = S_REM;
            end
            S_REM:
            begin
                cmd.rem    = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                cmd.check  = 1'b1;
                state_next = stat.invalid ? S_FIN : S_WALK;
            end
            S_WALK:
            begin
                cmd.step = 1'b1;
                if (stat.fits || stat.overflow)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_FIN);

endmodule

// ===== sv/gdad_dp.sv =====
// Datapath of the Gregorian date adder: input capture, year residues for the
// leap rule, validation, day-of-year count and the month-by-month walk.
// Depends on gdad_pkg.
module gdad_dp (
    input  logic               clk,
    input  gdad_pkg::in_t      item,
    input  gdad_pkg::dp_cmd_t  cmd,
    output gdad_pkg::dp_stat_t stat,
    output gdad_pkg::out_t     result
);
    import gdad_pkg::*;

    in_t         in_reg;
    logic [7:0]  quot_reg;
    logic [6:0]  rem100_reg;
    logic [1:0]  cent_reg;
    logic [13:0] year_reg;
    logic [3:0]  month_reg;
    logic [16:0] remain_reg;
    out_t        result_reg;

    logic [26:0] recip_prod;
    logic [14:0] hund_prod;
    logic [14:0] rem_diff;
    logic        leap;
    logic [4:0]  start_len;
    logic [4:0]  walk_len;
    logic        start_ok;
    logic [8:0]  days_prior;
    logic [16:0] doy_sum;

    // Year divided by 100 through a reciprocal multiply, then the remainder.
    assign recip_prod = in_reg.start_year * RECIP_100;
    assign hund_prod  = quot_reg * 7'd100;
    assign rem_diff   = {1'b0, in_reg.start_year} - hund_prod;

    // Leap flag of the year held in year_reg.
    assign leap = is_leap(year_reg[1:0], rem100_reg, cent_reg);

    // Start date validation.
    assign start_len = month_len(in_reg.start_month, leap);
    assign start_ok  = (in_reg.start_year != 14'd0) && (in_reg.start_year <= YEAR_MAX) &&
                       (start_len != 5'd0) && (in_reg.start_day != 5'd0) &&
                       (in_reg.start_day <= start_len);

    // Day of the year plus the days to add.
    assign days_prior = days_before(in_reg.start_month) +
                        {8'd0, (leap && (in_reg.start_month > 4'd2))};
    assign doy_sum    = {12'd0, in_reg.start_day} + {8'd0, days_prior} +
                        {1'b0, in_reg.days_to_add};

    // Walk status.
    assign walk_len      = month_len(month_reg, leap);
    assign stat.invalid  = !start_ok;
    assign stat.fits     = (remain_reg <= {12'd0, walk_len});
    assign stat.overflow = !stat.fits && (month_reg == 4'd12) && (year_reg == YEAR_MAX);

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= item;
        end
        if (cmd.quot)
        begin
            quot_reg <= recip_prod[RECIP_SHIFT +: 8];
        end
        if (cmd.rem)
        begin
            rem100_reg <= rem_diff[6:0];
            cent_reg   <= quot_reg[1:0];
            year_reg   <= in_reg.start_year;
        end
        if (cmd.check)
        begin
            remain_reg <= doy_sum;
            month_reg  <= 4'd1;
            if (!start_ok)
            begin
                result_reg <= '{new_year: 14'd0, new_month: 4'd0, new_day: 5'd0,
                                status: ST_INVALID};
            end
        end
        if (cmd.step)
        begin
            priority if (stat.fits)
            begin
                result_reg <= '{new_year: year_reg, new_month: month_reg,
                                new_day: remain_reg[4:0], status: ST_OK};
            end
            else if (stat.overflow)
            begin
                result_reg <= '{new_year: YEAR_MAX, new_month: 4'd12, new_day: 5'd31,
                                status: ST_OVERFLOW};
            end
            else
            begin
                remain_reg <= remain_reg - {12'd0, walk_len};
                if (month_reg == 4'd12)
                begin
                    // Year rollover keeps the leap residues in step.
                    month_reg <= 4'd1;
                    year_reg  <= year_reg + 14'd1;
                    if (rem100_reg == 7'd99)
                    begin
                        rem100_reg <= 7'd0;
                        cent_reg   <= cent_reg + 2'd1;
                    end
                    else
                    begin
                        rem100_reg <= rem100_reg + 7'd1;
                    end
                end
                else
                begin
                    month_reg <= month_reg + 4'd1;
                end
            end
        end
    end

    assign result = result_reg;

endmodule
